/* rtl/core/tptt_pkg.sv */
// ----------------------------------------------------------------------------
// tptt_pkg: shared constants for the tick-tock phase-trim timer
// Command codes, event codes, widths and scaling constants.
// ----------------------------------------------------------------------------
package tptt_pkg;

   localparam int CMD_W      = 3;
   localparam int PHASE_W    = 16;
   localparam int EVENT_W    = 2;
   localparam int OFFSET_W   = 16;
   localparam int INTERVAL_W = 16;
   localparam int COUNT_W    = 32;
   localparam int SHIFT_W    = 24;
   localparam int SCALED_W   = 24;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;

   localparam logic [CMD_W-1:0] CMD_STEP      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RESUME    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_PHASE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_INC_OFS   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DEC_OFS   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CLR_OFS   = 3'd6;

   localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
   localparam logic [EVENT_W-1:0] EV_TICK = 2'd1;
   localparam logic [EVENT_W-1:0] EV_TOCK = 2'd2;

   // offset step is 16 (shift by 4)
   localparam int SCALE_PER_US = 80;
   localparam int OFFSET_SHIFT = 4;

   localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 16'sd32767;
   localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = -16'sd32767;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd20000;

   // largest pending shift magnitude: a quarter of the largest interval, scaled
   localparam logic signed [SHIFT_W-1:0] SHIFT_MAX =
      SHIFT_W'(((1 << INTERVAL_W) - 1) / 4 * SCALE_PER_US);

   localparam logic [0:0] REG_INTERVAL = 1'b0;

   function automatic logic [SCALED_W-1:0] scale_us(input logic [INTERVAL_W-1:0] us);
      logic [SCALED_W-1:0] x;
      x = {{(SCALED_W-INTERVAL_W){1'b0}}, us};
      return x * SCALED_W'(SCALE_PER_US);
   endfunction

endpackage

/* rtl/core/tick_tock_phase_trim_timer.sv */
// ----------------------------------------------------------------------------
// tick_tock_phase_trim_timer: step-driven counter with tick/tock alarm
// Alarm-driven half-period timer with one-shot phase trim and offset steps.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one command per
//   transaction: time step, resume, stop, set phase, or offset step/clear.
//   Every request produces exactly one response transaction on the rsp_
//   channel with the event fired (none, tick, tock) and the current
//   frequency offset.
//   The response is registered and shows on the cycle after the request
//   is taken. One request is taken every cycle while the receiver does
//   not stall; each takes a single pass through the deadline adder.
//   When the receiver stalls, the response register holds its transaction
//   and req_stall is raised until the response drains; a request is still
//   taken in the cycle the held response leaves.
//   The APB port holds interval_us at address 0; the scaled interval is
//   computed on the write. Write it only while idle.
//   Synchronous reset clears the counter, alarm, deadline, phase, offset
//   and run flag, empties the response register, and sets interval_us to
//   20000.
// ----------------------------------------------------------------------------
module tick_tock_phase_trim_timer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tptt_pkg::CMD_W-1:0]             req_command,
   input  logic signed [tptt_pkg::PHASE_W-1:0]    req_phase_shift_us,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tptt_pkg::EVENT_W-1:0]           rsp_event_res,
   output logic signed [tptt_pkg::OFFSET_W-1:0]   rsp_freq_offset_now,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [tptt_pkg::ADDR_W-1:0]            paddr,
   input  logic [tptt_pkg::DATA_W-1:0]            pwdata,
   output logic [tptt_pkg::DATA_W-1:0]            prdata,
   output logic                                   pready
);

   logic [tptt_pkg::COUNT_W-1:0]           time_count_ff,    time_count_in;
   logic [tptt_pkg::COUNT_W-1:0]           alarm_target_ff,  alarm_target_in;
   logic [tptt_pkg::COUNT_W-1:0]           next_deadline_ff, next_deadline_in;
   logic                                   tick_phase_ff,    tick_phase_in;
   logic signed [tptt_pkg::SHIFT_W-1:0]    pending_shift_ff, pending_shift_in;
   logic signed [tptt_pkg::OFFSET_W-1:0]   offset_steps_ff,  offset_steps_in;
   logic                                   run_flag_ff,      run_flag_in;
   logic [tptt_pkg::INTERVAL_W-1:0]        interval_us_ff,   interval_us_in;
   logic [tptt_pkg::SCALED_W-1:0]          scaled_ff,        scaled_in;

   logic                                   rsp_valid_ff,     rsp_valid_in;
   logic [tptt_pkg::EVENT_W-1:0]           rsp_event_ff,     rsp_event_in;
   logic signed [tptt_pkg::OFFSET_W-1:0]   rsp_offset_ff;

   logic                                   accept;
   logic                                   csr_write;
   logic [tptt_pkg::COUNT_W-1:0]           count_inc;
   logic                                   fire;
   logic [tptt_pkg::COUNT_W-1:0]           half_term;
   logic [tptt_pkg::COUNT_W-1:0]           offset_term;
   logic [tptt_pkg::COUNT_W-1:0]           shift_term;
   logic signed [tptt_pkg::PHASE_W:0]      lim;
   logic signed [tptt_pkg::PHASE_W:0]      req_ext;
   logic signed [tptt_pkg::PHASE_W:0]      clamped;
   logic signed [tptt_pkg::SHIFT_W-1:0]    clamped_ext;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[2] == tptt_pkg::REG_INTERVAL)
                      ? {{(tptt_pkg::DATA_W-tptt_pkg::INTERVAL_W){1'b0}}, interval_us_ff}
                      : '0;

   assign count_inc   = time_count_ff + 32'd1;
   assign fire        = run_flag_ff & (count_inc == alarm_target_ff);
   assign half_term   = {{(tptt_pkg::COUNT_W-tptt_pkg::SCALED_W){1'b0}}, scaled_ff >> 1};
   assign offset_term = {{(tptt_pkg::COUNT_W-tptt_pkg::OFFSET_W){offset_steps_ff[15]}},
                         offset_steps_ff} << tptt_pkg::OFFSET_SHIFT;
   assign shift_term  = tick_phase_ff ? '0
                        : {{(tptt_pkg::COUNT_W-tptt_pkg::SHIFT_W){pending_shift_ff[23]}},
                           pending_shift_ff};

   assign lim     = $signed({3'b000, interval_us_ff[15:2]});
   assign req_ext = {req_phase_shift_us[15], req_phase_shift_us};

   always_comb begin
      if (req_ext > lim) begin
         clamped = lim;
      end else if (req_ext < -lim) begin
         clamped = -lim;
      end else begin
         clamped = req_ext;
      end
   end

   assign clamped_ext = {{(tptt_pkg::SHIFT_W-tptt_pkg::PHASE_W-1){clamped[16]}}, clamped};

   always_comb begin
      time_count_in    = time_count_ff;
      alarm_target_in  = alarm_target_ff;
      next_deadline_in = next_deadline_ff;
      tick_phase_in    = tick_phase_ff;
      pending_shift_in = pending_shift_ff;
      offset_steps_in  = offset_steps_ff;
      run_flag_in      = run_flag_ff;
      rsp_event_in     = tptt_pkg::EV_NONE;
      if (accept) begin
         case (req_command)
            tptt_pkg::CMD_STEP: begin
               time_count_in = count_inc;
               if (fire) begin
                  next_deadline_in = next_deadline_ff + half_term + offset_term + shift_term;
                  alarm_target_in  = next_deadline_in;
                  tick_phase_in    = ~tick_phase_ff;
                  if (tick_phase_ff) begin
                     rsp_event_in = tptt_pkg::EV_TICK;
                  end else begin
                     rsp_event_in     = tptt_pkg::EV_TOCK;
                     pending_shift_in = '0;
                  end
               end
            end
            tptt_pkg::CMD_RESUME: begin
               run_flag_in     = 1'b1;
               alarm_target_in = {{(tptt_pkg::COUNT_W-tptt_pkg::SCALED_W){1'b0}}, scaled_ff};
            end
            tptt_pkg::CMD_STOP: begin
               run_flag_in = 1'b0;
            end
            tptt_pkg::CMD_SET_PHASE: begin
               pending_shift_in = clamped_ext
                                  * $signed(tptt_pkg::SHIFT_W'(tptt_pkg::SCALE_PER_US));
            end
            tptt_pkg::CMD_INC_OFS: begin
               if (offset_steps_ff < tptt_pkg::OFFSET_MAX) begin
                  offset_steps_in = offset_steps_ff + 16'sd1;
               end
            end
            tptt_pkg::CMD_DEC_OFS: begin
               if (offset_steps_ff > tptt_pkg::OFFSET_MIN) begin
                  offset_steps_in = offset_steps_ff - 16'sd1;
               end
            end
            tptt_pkg::CMD_CLR_OFS: begin
               offset_steps_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      interval_us_in = interval_us_ff;
      scaled_in      = scaled_ff;
      if (csr_write && paddr[2] == tptt_pkg::REG_INTERVAL) begin
         interval_us_in = pwdata[15:0];
         scaled_in      = tptt_pkg::scale_us(pwdata[15:0]);
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         time_count_ff    <= '0;
         alarm_target_ff  <= '0;
         next_deadline_ff <= '0;
         tick_phase_ff    <= 1'b0;
         pending_shift_ff <= '0;
         offset_steps_ff  <= '0;
         run_flag_ff      <= 1'b0;
         interval_us_ff   <= tptt_pkg::INTERVAL_RESET;
         scaled_ff        <= tptt_pkg::scale_us(tptt_pkg::INTERVAL_RESET);
         rsp_valid_ff     <= 1'b0;
      end else begin
         time_count_ff    <= time_count_in;
         alarm_target_ff  <= alarm_target_in;
         next_deadline_ff <= next_deadline_in;
         tick_phase_ff    <= tick_phase_in;
         pending_shift_ff <= pending_shift_in;
         offset_steps_ff  <= offset_steps_in;
         run_flag_ff      <= run_flag_in;
         interval_us_ff   <= interval_us_in;
         scaled_ff        <= scaled_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_event_ff  <= rsp_event_in;
         rsp_offset_ff <= offset_steps_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = rsp_event_ff;
   assign rsp_freq_offset_now = rsp_offset_ff;

   // tock consumes the one-shot shift and flips to tick
   a_tock_clears_shift: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_event_in == tptt_pkg::EV_TOCK |=> pending_shift_ff == '0 && tick_phase_ff)
      else $error("tock did not clear pending shift");

   a_event_needs_run: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_event_in != tptt_pkg::EV_NONE |-> run_flag_ff)
      else $error("event fired while stopped");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      offset_steps_ff != 16'sh8000)
      else $error("offset left saturation range");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      pending_shift_ff <= tptt_pkg::SHIFT_MAX && pending_shift_ff >= -tptt_pkg::SHIFT_MAX)
      else $error("pending shift out of clamp range");

   a_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept && !(rsp_valid_ff && rsp_stall) |=> !rsp_valid_ff)
      else $error("response without transaction");

endmodule
